[rtl/core/krt_pkg.sv]
// Package for the keyed record table: widths, command and status codes, states.
package krt_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int NAME_BYTES  = 9;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int REC_W       = 64 + 8 + 8 + 31;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_LIST   = 3'd3,
        CMD_SORTED = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,      // search / delete / list walk: read issued, data next cycle
        S_SCAN_CHK,
        S_SHIFT,     // delete: copy entry j+1 to j
        S_SHIFT_WR,
        S_SORT_RD,   // read key i
        S_SORT_KEY,
        S_SORT_CMP,  // read order[j-1] and its key
        S_SORT_CMP2,
        S_SORT_CMP3,
        S_EMIT_RD,   // sorted emit: read order[i]
        S_EMIT_REC,
        S_EMIT_CHK,
        S_OUT        // search: send the held final hit with last
    } state_t;

    function automatic logic [71:0] canon_name(input logic [63:0] hi, input logic [7:0] lo);
        logic [71:0] raw;
        logic [71:0] res;
        logic        keep;
        raw  = {hi, lo};
        res  = '0;
        keep = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if (k >= NAME_BYTES)
                keep = 1'b0;
            if (keep && raw[71-8*k -: 8] != 8'd0)
                res[71-8*k -: 8] = raw[71-8*k -: 8];
            else
                keep = 1'b0;
        end
        return res;
    endfunction
endpackage

[rtl/core/keyed_record_table_sorted_list.sv]
// Top level of the keyed record table with stable sorted listing.
//
// Record table of up to 32 entries (9-byte name, age, phone) kept in insertion
// order in one synchronous record memory plus a small sort-order memory, both
// with registered reads. One command per input transfer; results leave through
// a one-entry output register, last marking the final result of a command.
// Append, and the empty and full answers, are set up straight from the idle
// state; delete, search and list walk the table entry by entry (delete then
// shifts each later entry down one slot, search sends its held final hit in
// an extra step); the sorted listing runs an insertion sort of the record
// indices through the memories, then emits the records in key order. Each
// result may stall on the output side; commands are taken one at a time.
// Unknown commands are dropped.
module keyed_record_table_sorted_list
    import krt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        ready_in,
    input  logic [2:0]  command,
    input  logic [63:0] name_high,
    input  logic [7:0]  name_low,
    input  logic [7:0]  age,
    input  logic [30:0] phone,
    output logic        valid_out,
    input  logic        ready_out,
    output logic [1:0]  status,
    output logic [63:0] rec_name_high,
    output logic [7:0]  rec_name_low,
    output logic [7:0]  rec_age,
    output logic [30:0] rec_phone,
    output logic        last
);
    // record memory and sort-order memory
    logic [REC_W-1:0] rec_mem [TABLE_DEPTH];
    logic [IDX_W-1:0] ord_mem [TABLE_DEPTH];

    logic [REC_W-1:0] rec_rd_reg;
    logic [IDX_W-1:0] ord_rd_reg;
    logic [IDX_W-1:0] rec_raddr, ord_raddr, rec_waddr, ord_waddr;
    logic [REC_W-1:0] rec_wdata;
    logic [IDX_W-1:0] ord_wdata;
    logic             rec_we, ord_we;

    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_mem[rec_waddr] <= rec_wdata;
        rec_rd_reg <= rec_mem[rec_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [71:0]      key_reg, key_next;
    logic             hit_reg, hit_next;
    logic [71:0]      ikey_reg, ikey_next;
    logic [REC_W-1:0] hold_reg, hold_next;

    logic             ov_reg, ov_next;
    logic [1:0]       ost_reg, ost_next;
    logic [REC_W-1:0] orec_reg, orec_next;
    logic             olast_reg, olast_next;

    logic [71:0] cname;
    logic        out_free;
    logic        rd_match;

    assign cname    = canon_name(name_high, name_low);
    assign out_free = !ov_reg || ready_out;
    assign rd_match = rec_rd_reg[REC_W-1 -: 72] == key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        hit_reg   <= hit_next;
        ikey_reg  <= ikey_next;
        hold_reg  <= hold_next;
        ost_reg   <= ost_next;
        orec_reg  <= orec_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        hit_next   = hit_reg;
        ikey_next  = ikey_reg;
        hold_next  = hold_reg;
        ov_next    = ov_reg && !ready_out;
        ost_next   = ost_reg;
        orec_next  = orec_reg;
        olast_next = olast_reg;
        ready_in   = 1'b0;
        rec_raddr  = i_reg[IDX_W-1:0];
        ord_raddr  = i_reg[IDX_W-1:0];
        rec_we     = 1'b0;
        rec_waddr  = count_reg[IDX_W-1:0];
        rec_wdata  = {cname, age, phone};
        ord_we     = 1'b0;
        ord_waddr  = j_reg[IDX_W-1:0];
        ord_wdata  = i_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                ready_in = out_free;
                if (valid_in && out_free)
                begin
                    cmd_next = command;
                    key_next = cname;
                    hit_next = 1'b0;
                    i_next   = '0;
                    if (command == CMD_APPEND)
                    begin
                        ov_next    = 1'b1;
                        olast_next = 1'b1;
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            ost_next  = ST_FULL;
                            orec_next = '0;
                        end
                        else
                        begin
                            rec_we     = 1'b1;
                            ost_next   = ST_OK;
                            orec_next  = {cname, age, phone};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (command <= CMD_SORTED)
                    begin
                        if (count_reg == '0)
                        begin
                            ov_next    = 1'b1;
                            olast_next = 1'b1;
                            ost_next   = ST_EMPTY;
                            orec_next  = '0;
                        end
                        else if (command == CMD_SORTED)
                            state_next = S_SORT_RD;
                        else
                            state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rec_raddr  = i_reg[IDX_W-1:0];
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (out_free)
                begin
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        // Hold each hit one step back so the final one can carry last.
                        if (rd_match)
                        begin
                            hold_next = rec_rd_reg;
                            hit_next  = 1'b1;
                            if (hit_reg)
                            begin
                                ov_next    = 1'b1;
                                ost_next   = ST_OK;
                                orec_next  = hold_reg;
                                olast_next = 1'b0;
                            end
                        end
                    end
                    else if (cmd_reg == CMD_LIST)
                    begin
                        ov_next    = 1'b1;
                        ost_next   = ST_OK;
                        orec_next  = rec_rd_reg;
                        olast_next = (i_reg + 1'b1) == count_reg;
                    end
                    else if (rd_match)
                    begin
                        ov_next    = 1'b1;
                        ost_next   = ST_OK;
                        orec_next  = rec_rd_reg;
                        olast_next = 1'b1;
                        j_next     = i_reg;
                        state_next = S_SHIFT;
                    end
                    if (!(cmd_reg == CMD_DELETE && rd_match))
                    begin
                        if ((i_reg + 1'b1) == count_reg)
                        begin
                            state_next = S_IDLE;
                            if (cmd_reg == CMD_SEARCH && (hit_reg || rd_match))
                                state_next = S_OUT;
                            else if (cmd_reg != CMD_LIST)
                            begin
                                ov_next    = 1'b1;
                                ost_next   = ST_NOTFOUND;
                                orec_next  = '0;
                                olast_next = 1'b1;
                            end
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                if ((j_reg + 1'b1) >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rec_raddr  = IDX_W'(j_reg + 1'b1);
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                rec_we     = 1'b1;
                rec_waddr  = j_reg[IDX_W-1:0];
                rec_wdata  = rec_rd_reg;
                j_next     = j_reg + 1'b1;
                state_next = S_SHIFT;
            end
            S_SORT_RD:
            begin
                rec_raddr  = i_reg[IDX_W-1:0];
                state_next = S_SORT_KEY;
            end
            S_SORT_KEY:
            begin
                ikey_next  = rec_rd_reg[REC_W-1 -: 72];
                j_next     = i_reg;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if (j_reg == '0)
                begin
                    ord_we     = 1'b1;
                    state_next = S_SORT_CMP3;
                end
                else
                begin
                    ord_raddr  = IDX_W'(j_reg - 1'b1);
                    state_next = S_SORT_CMP2;
                end
            end
            S_SORT_CMP2:
            begin
                // keep order[j-1] on the read port for the move
                ord_raddr  = IDX_W'(j_reg - 1'b1);
                rec_raddr  = ord_rd_reg;
                state_next = S_SORT_CMP3;
                hit_next   = 1'b1;
            end
            S_SORT_CMP3:
            begin
                if (j_reg != '0 && hit_reg)
                begin
                    hit_next = 1'b0;
                    if (rec_rd_reg[REC_W-1 -: 72] > ikey_reg)
                    begin
                        // move order[j-1] up one slot
                        ord_we     = 1'b1;
                        ord_wdata  = ord_rd_reg;
                        j_next     = j_reg - 1'b1;
                        state_next = S_SORT_CMP;
                    end
                    else
                    begin
                        ord_we     = 1'b1;
                        state_next = S_SORT_CMP3;
                        j_next     = '0;
                        ord_waddr  = j_reg[IDX_W-1:0];
                    end
                end
                else
                begin
                    hit_next = 1'b0;
                    if ((i_reg + 1'b1) == count_reg)
                    begin
                        i_next     = '0;
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_SORT_RD;
                    end
                end
            end
            S_EMIT_RD:
            begin
                ord_raddr  = i_reg[IDX_W-1:0];
                state_next = S_EMIT_REC;
            end
            S_EMIT_REC:
            begin
                rec_raddr  = ord_rd_reg;
                state_next = S_EMIT_CHK;
            end
            S_EMIT_CHK:
            begin
                // hold the record on the read port while the output stalls
                rec_raddr = ord_rd_reg;
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_OK;
                    orec_next  = rec_rd_reg;
                    olast_next = (i_reg + 1'b1) == count_reg;
                    if ((i_reg + 1'b1) == count_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_OK;
                    orec_next  = hold_reg;
                    olast_next = 1'b1;
                    hit_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign valid_out     = ov_reg;
    assign status        = ost_reg;
    assign rec_name_high = orec_reg[REC_W-1 -: 64];
    assign rec_name_low  = orec_reg[46:39];
    assign rec_age       = orec_reg[38:31];
    assign rec_phone     = orec_reg[30:0];
    assign last          = olast_reg;

    // Input is taken only in the idle state.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_in |-> state_reg == S_IDLE)
        else $error("input taken outside idle");

    // Record count never exceeds the table depth.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("record count overflow");

    // A held result is not overwritten before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && !ready_out |=> valid_out && $stable(rec_name_high) && $stable(status))
        else $error("result changed while stalled");
endmodule
